[rtl/core/assert_macros.svh]
// Assertion macros for the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, held off during reset.
`define DLPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a property at every rising clock edge, also during reset.
`define DLPR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/core/dlpr_pkg.sv]
`timescale 1ns / 1ps
package dlpr_pkg;

   localparam logic [7:0]  DATA_LEADER = 8'h30;
   localparam logic [7:0]  CTRL_LEADER = 8'h69;
   localparam logic [7:0]  TRAIL_BYTE  = 8'hAA;
   localparam logic [31:0] INITIAL_ID  = 32'h8080_0000;
   localparam logic [31:0] SYNC_BIT    = 32'h0000_0800;
   localparam logic [15:0] T_ACK       = 16'd4;
   localparam logic [15:0] T_RESEND    = 16'd5;
   localparam logic [15:0] T_RESET     = 16'd6;

   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;

   localparam logic [1:0] KIND_HDR    = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_CTRL   = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   localparam logic [1:0] ST_RECEIVED = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_RESEND   = 2'd2;

   localparam logic [11:0] HDR_LEN_RESET = 12'd16;
   localparam logic [15:0] MAX_CNT_RESET = 16'd4000;
   localparam logic [11:0] DLEN_MAX      = 12'hFFF;

   localparam logic [7:0] REG_HDR_LEN = 8'd0;
   localparam logic [7:0] REG_MAX_CNT = 8'd1;

   localparam int FIFO_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_LEADER = 4'd0,
      PH_TYPE   = 4'd1,
      PH_COUNT  = 4'd2,
      PH_ID     = 4'd3,
      PH_CSUM   = 4'd4,
      PH_HDR    = 4'd5,
      PH_DATA   = 4'd6,
      PH_TRAIL  = 4'd7
   } phase_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  rx_byte;
      logic [15:0] expected_type;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [15:0] control_type;
      logic [31:0] control_id;
      logic [1:0]  status;
      logic [11:0] data_length;
      logic        last;
   } result_type;

   typedef struct packed {
      logic        write;
      logic [7:0]  index;
      logic [15:0] data;
   } cfg_wr_type;

   function automatic result_type mk_res(logic [1:0] kind, logic [7:0] pb, logic [15:0] ct,
                                         logic [31:0] cid, logic [1:0] st, logic [11:0] dl);
      result_type r;
      r.kind = kind;
      r.payload_byte = pb;
      r.control_type = ct;
      r.control_id = cid;
      r.status = st;
      r.data_length = dl;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

[rtl/core/dlpr_if.sv]
`timescale 1ns / 1ps
// Input channel: one receive event per item.
interface dlpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  rx_byte;
   logic [15:0] expected_type;
   modport source (output valid, action, rx_byte, expected_type, input ready);
   modport sink (input valid, action, rx_byte, expected_type, output ready);
endinterface

// Result channel: one result per item.
interface dlpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [15:0] control_type;
   logic [31:0] control_id;
   logic [1:0]  status;
   logic [11:0] data_length;
   logic        last;
   modport source (output valid, kind, payload_byte, control_type, control_id, status,
                   data_length, last, input ready);
   modport sink (input valid, kind, payload_byte, control_type, control_id, status,
                 data_length, last, output ready);
endinterface

// Configuration write channel.
interface dlpr_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/dlpr_deframer.sv]
`timescale 1ns / 1ps
// Packet deframer: consumes one event per cycle while step is high and yields up to two results.
module dlpr_deframer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  dlpr_pkg::item_type   item,
   input  dlpr_pkg::cfg_wr_type cfg,
   output logic [1:0]           res_count,
   output dlpr_pkg::result_type res0,
   output dlpr_pkg::result_type res1
);

   dlpr_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  run_ff, run_in;
   logic [7:0]  lead_ff, lead_in;
   logic [1:0]  fidx_ff, fidx_in;
   logic [15:0] ptype_ff, ptype_in;
   logic [15:0] bcount_ff, bcount_in;
   logic [31:0] pid_ff, pid_in;
   logic [31:0] csum_ff, csum_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] id_exp_ff, id_exp_in;
   logic [31:0] id_send_ff, id_send_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [11:0] hdr_len_ff;
   logic [15:0] max_cnt_ff;

   logic [31:0] lane;
   logic [11:0] dlen_sat;
   logic        is_ctrl;

   assign lane = {24'd0, item.rx_byte} << {fidx_ff, 3'b000};
   assign dlen_sat = (dlen_ff > 16'(dlpr_pkg::DLEN_MAX)) ? dlpr_pkg::DLEN_MAX : dlen_ff[11:0];
   assign is_ctrl = (lead_ff == dlpr_pkg::CTRL_LEADER);

   // Next state and results for the current event.
   always_comb begin
      dlpr_pkg::result_type ack_r, rsd_r, fin_r;
      logic done;
      phase_in = phase_ff;
      run_in = run_ff;
      lead_in = lead_ff;
      fidx_in = fidx_ff;
      ptype_in = ptype_ff;
      bcount_in = bcount_ff;
      pid_in = pid_ff;
      csum_in = csum_ff;
      left_in = left_ff;
      sum_in = sum_ff;
      id_exp_in = id_exp_ff;
      id_send_in = id_send_ff;
      dlen_in = dlen_ff;
      res_count = 2'd0;
      res0 = '0;
      res1 = '0;
      done = 1'b0;
      rsd_r = dlpr_pkg::mk_res(dlpr_pkg::KIND_CTRL, 8'd0, dlpr_pkg::T_RESEND, 32'd0,
                               dlpr_pkg::ST_RECEIVED, 12'd0);
      ack_r = dlpr_pkg::mk_res(dlpr_pkg::KIND_CTRL, 8'd0, dlpr_pkg::T_ACK, pid_ff,
                               dlpr_pkg::ST_RECEIVED, 12'd0);
      fin_r = dlpr_pkg::mk_res(dlpr_pkg::KIND_FINISH, 8'd0, 16'd0, 32'd0,
                               dlpr_pkg::ST_RECEIVED, 12'd0);
      case (phase_ff)
         dlpr_pkg::PH_LEADER: begin
            if (item.action == dlpr_pkg::ACT_TIMEOUT) begin
               fin_r.status = dlpr_pkg::ST_TIMEOUT;
               res0 = fin_r;
               res_count = 2'd1;
               run_in = 3'd0;
               lead_in = 8'd0;
            end else if (item.action != dlpr_pkg::ACT_BYTE) begin
               run_in = 3'd0;
            end else if (item.rx_byte == dlpr_pkg::DATA_LEADER ||
                         item.rx_byte == dlpr_pkg::CTRL_LEADER) begin
               if (run_ff == 3'd0 || item.rx_byte != lead_ff) begin
                  lead_in = item.rx_byte;
                  run_in = 3'd1;
               end else begin
                  run_in = run_ff + 3'd1;
               end
               if (run_in >= 3'd4) begin
                  phase_in = dlpr_pkg::PH_TYPE;
                  fidx_in = 2'd0;
                  ptype_in = 16'd0;
                  bcount_in = 16'd0;
                  pid_in = 32'd0;
                  csum_in = 32'd0;
               end
            end else begin
               run_in = 3'd0;
            end
         end
         dlpr_pkg::PH_TYPE, dlpr_pkg::PH_COUNT, dlpr_pkg::PH_ID, dlpr_pkg::PH_CSUM: begin
            if (item.action == dlpr_pkg::ACT_TIMEOUT) begin
               fin_r.status = dlpr_pkg::ST_TIMEOUT;
               res0 = fin_r;
               res_count = 2'd1;
               phase_in = dlpr_pkg::PH_LEADER;
               run_in = 3'd0;
               lead_in = 8'd0;
            end else if (item.action != dlpr_pkg::ACT_BYTE) begin
               if (!is_ctrl) begin
                  res0 = rsd_r;
                  res_count = 2'd1;
               end
               phase_in = dlpr_pkg::PH_LEADER;
               run_in = 3'd0;
               lead_in = 8'd0;
            end else begin
               // Merge the byte into its little-endian lane.
               unique case (phase_ff)
                  dlpr_pkg::PH_TYPE:  ptype_in = ptype_ff | lane[15:0];
                  dlpr_pkg::PH_COUNT: bcount_in = bcount_ff | lane[15:0];
                  dlpr_pkg::PH_ID:    pid_in = pid_ff | lane;
                  default:            csum_in = csum_ff | lane;
               endcase
               if (phase_ff == dlpr_pkg::PH_TYPE || phase_ff == dlpr_pkg::PH_COUNT) begin
                  done = (fidx_ff >= 2'd1);
               end else begin
                  done = (fidx_ff == 2'd3);
               end
               if (!done) begin
                  fidx_in = fidx_ff + 2'd1;
               end else begin
                  fidx_in = 2'd0;
                  unique case (phase_ff)
                     dlpr_pkg::PH_TYPE: begin
                        if (is_ctrl && ptype_in == dlpr_pkg::T_RESEND) begin
                           fin_r.status = dlpr_pkg::ST_RESEND;
                           res0 = fin_r;
                           res_count = 2'd1;
                           phase_in = dlpr_pkg::PH_LEADER;
                           run_in = 3'd0;
                           lead_in = 8'd0;
                        end else begin
                           phase_in = dlpr_pkg::PH_COUNT;
                        end
                     end
                     dlpr_pkg::PH_COUNT: phase_in = dlpr_pkg::PH_ID;
                     dlpr_pkg::PH_ID:    phase_in = dlpr_pkg::PH_CSUM;
                     default: begin
                        // Header complete: decide on the packet.
                        if (is_ctrl) begin
                           if (ptype_ff == dlpr_pkg::T_ACK) begin
                              if (pid_ff == (id_send_ff & ~dlpr_pkg::SYNC_BIT) &&
                                  item.expected_type == dlpr_pkg::T_ACK) begin
                                 id_send_in = id_send_ff ^ 32'd1;
                                 res0 = fin_r;
                                 res_count = 2'd1;
                              end
                           end else if (ptype_ff == dlpr_pkg::T_RESET) begin
                              id_send_in = dlpr_pkg::INITIAL_ID;
                              id_exp_in = dlpr_pkg::INITIAL_ID;
                              res0 = rsd_r;
                              res0.control_type = dlpr_pkg::T_RESET;
                              res1 = fin_r;
                              res1.status = dlpr_pkg::ST_RESEND;
                              res_count = 2'd2;
                           end else if (ptype_ff == dlpr_pkg::T_RESEND) begin
                              fin_r.status = dlpr_pkg::ST_RESEND;
                              res0 = fin_r;
                              res_count = 2'd1;
                           end
                           phase_in = dlpr_pkg::PH_LEADER;
                           run_in = 3'd0;
                           lead_in = 8'd0;
                        end else if (item.expected_type == dlpr_pkg::T_ACK) begin
                           if (pid_ff == id_exp_ff) begin
                              res0 = rsd_r;
                              res1 = fin_r;
                              res_count = 2'd2;
                              id_send_in = id_send_ff ^ 32'd1;
                           end else begin
                              res0 = ack_r;
                              res_count = 2'd1;
                           end
                           phase_in = dlpr_pkg::PH_LEADER;
                           run_in = 3'd0;
                           lead_in = 8'd0;
                        end else if (bcount_ff > max_cnt_ff ||
                                     bcount_ff < {4'd0, hdr_len_ff}) begin
                           res0 = rsd_r;
                           res_count = 2'd1;
                           phase_in = dlpr_pkg::PH_LEADER;
                           run_in = 3'd0;
                           lead_in = 8'd0;
                        end else begin
                           dlen_in = bcount_ff - {4'd0, hdr_len_ff};
                           sum_in = 32'd0;
                           if (hdr_len_ff != 12'd0) begin
                              phase_in = dlpr_pkg::PH_HDR;
                              left_in = {4'd0, hdr_len_ff};
                           end else if (dlen_in != 16'd0) begin
                              phase_in = dlpr_pkg::PH_DATA;
                              left_in = dlen_in;
                           end else begin
                              phase_in = dlpr_pkg::PH_TRAIL;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         dlpr_pkg::PH_HDR, dlpr_pkg::PH_DATA: begin
            if (item.action != dlpr_pkg::ACT_BYTE) begin
               res0 = rsd_r;
               res_count = 2'd1;
               phase_in = dlpr_pkg::PH_LEADER;
               run_in = 3'd0;
               lead_in = 8'd0;
            end else begin
               res0 = dlpr_pkg::mk_res((phase_ff == dlpr_pkg::PH_HDR) ? dlpr_pkg::KIND_HDR
                                       : dlpr_pkg::KIND_DATA, item.rx_byte, 16'd0, 32'd0,
                                       dlpr_pkg::ST_RECEIVED, 12'd0);
               res_count = 2'd1;
               sum_in = sum_ff + {24'd0, item.rx_byte};
               left_in = left_ff - 16'd1;
               if (left_in == 16'd0) begin
                  if (phase_ff == dlpr_pkg::PH_HDR && dlen_ff != 16'd0) begin
                     phase_in = dlpr_pkg::PH_DATA;
                     left_in = dlen_ff;
                  end else begin
                     phase_in = dlpr_pkg::PH_TRAIL;
                  end
               end
            end
         end
         dlpr_pkg::PH_TRAIL: begin
            res_count = 2'd1;
            if (item.action != dlpr_pkg::ACT_BYTE || item.rx_byte != dlpr_pkg::TRAIL_BYTE) begin
               res0 = rsd_r;
            end else if (item.expected_type != ptype_ff) begin
               res0 = ack_r;
            end else if (pid_ff != dlpr_pkg::INITIAL_ID &&
                         pid_ff != (dlpr_pkg::INITIAL_ID ^ 32'd1)) begin
               res0 = rsd_r;
            end else if (pid_ff != id_exp_ff) begin
               res0 = ack_r;
            end else if (sum_ff != csum_ff) begin
               res0 = rsd_r;
            end else begin
               res0 = ack_r;
               res1 = fin_r;
               res1.data_length = dlen_sat;
               res_count = 2'd2;
               id_exp_in = id_exp_ff ^ 32'd1;
            end
            phase_in = dlpr_pkg::PH_LEADER;
            run_in = 3'd0;
            lead_in = 8'd0;
         end
         default: begin
            phase_in = dlpr_pkg::PH_LEADER;
            run_in = 3'd0;
            lead_in = 8'd0;
         end
      endcase
      // Mark the final result of this event.
      if (res_count == 2'd1) res0.last = 1'b1;
      if (res_count == 2'd2) res1.last = 1'b1;
   end

   // Control and id state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dlpr_pkg::PH_LEADER;
         run_ff <= 3'd0;
         lead_ff <= 8'd0;
         fidx_ff <= 2'd0;
         ptype_ff <= 16'd0;
         bcount_ff <= 16'd0;
         pid_ff <= 32'd0;
         csum_ff <= 32'd0;
         left_ff <= 16'd0;
         sum_ff <= 32'd0;
         dlen_ff <= 16'd0;
         id_exp_ff <= dlpr_pkg::INITIAL_ID;
         id_send_ff <= dlpr_pkg::INITIAL_ID | dlpr_pkg::SYNC_BIT;
      end else if (step) begin
         phase_ff <= phase_in;
         run_ff <= run_in;
         lead_ff <= lead_in;
         fidx_ff <= fidx_in;
         ptype_ff <= ptype_in;
         bcount_ff <= bcount_in;
         pid_ff <= pid_in;
         csum_ff <= csum_in;
         left_ff <= left_in;
         sum_ff <= sum_in;
         dlen_ff <= dlen_in;
         id_exp_ff <= id_exp_in;
         id_send_ff <= id_send_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_len_ff <= dlpr_pkg::HDR_LEN_RESET;
         max_cnt_ff <= dlpr_pkg::MAX_CNT_RESET;
      end else if (cfg.write) begin
         if (cfg.index == dlpr_pkg::REG_HDR_LEN) hdr_len_ff <= cfg.data[11:0];
         if (cfg.index == dlpr_pkg::REG_MAX_CNT) max_cnt_ff <= cfg.data;
      end
   end

endmodule

[rtl/core/debug_link_packet_receiver.sv]
`timescale 1ns / 1ps
// Channel    Dir  Payload
// req_chan   in   action, rx_byte, expected_type
// rsp_chan   out  kind, payload_byte, control_type, control_id, status, data_length, last
// csr_chan   in   index, data (always ready)
//
// Each event is decoded in the cycle it is accepted; its results enter a result queue.
// Results are stored as the event is accepted; each is offered once those ahead are taken.
// One event per cycle is taken while the queue has room for two results.
// An event with two results is popped as two results; such events set the sustained rate.
// Reset is synchronous and active high; it restores ids, phase and registers.
// A stalled result side fills the queue, and then the input side stops.
`include "assert_macros.svh"
module debug_link_packet_receiver #(
   parameter int Depth = dlpr_pkg::FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   dlpr_req_if.sink   req_chan,
   dlpr_rsp_if.source rsp_chan,
   dlpr_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(Depth);

   dlpr_pkg::result_type fifo_mem [Depth];
   dlpr_pkg::result_type res0, res1, head;
   dlpr_pkg::item_type   item;
   dlpr_pkg::cfg_wr_type cfg;
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   count_ff, count_in;
   logic [1:0]    res_count;
   logic          step, pop;

   assign item.action = req_chan.action;
   assign item.rx_byte = req_chan.rx_byte;
   assign item.expected_type = req_chan.expected_type;
   assign cfg.write = csr_chan.valid;
   assign cfg.index = csr_chan.index;
   assign cfg.data = csr_chan.data;
   assign csr_chan.ready = 1'b1;

   assign req_chan.ready = (count_ff <= (AW+1)'(Depth - 2));
   assign step = req_chan.valid && req_chan.ready;
   assign pop = rsp_chan.valid && rsp_chan.ready;

   dlpr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .cfg       (cfg),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (step && res_count != 2'd0) fifo_mem[wr_ff] <= res0;
      if (step && res_count == 2'd2) fifo_mem[wr_ff + AW'(1)] <= res1;
   end

   always_comb begin
      count_in = count_ff;
      if (step) count_in = count_in + (AW+1)'(res_count);
      if (pop) count_in = count_in - (AW+1)'(1);
   end

   // Queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (step) wr_ff <= wr_ff + AW'(res_count);
         if (pop) rd_ff <= rd_ff + AW'(1);
         count_ff <= count_in;
      end
   end

   assign head = fifo_mem[rd_ff];
   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.kind = head.kind;
   assign rsp_chan.payload_byte = head.payload_byte;
   assign rsp_chan.control_type = head.control_type;
   assign rsp_chan.control_id = head.control_id;
   assign rsp_chan.status = head.status;
   assign rsp_chan.data_length = head.data_length;
   assign rsp_chan.last = head.last;

   `DLPR_ASSERT(a_count_bound, count_ff <= (AW+1)'(Depth), "queue overfilled")
   `DLPR_ASSERT(a_room_on_accept, step |-> count_ff <= (AW+1)'(Depth - 2), "no room for item")
   `DLPR_ASSERT(a_pop_drains, (pop && !step) |=> count_ff == $past(count_ff) - (AW+1)'(1),
      "queue count off")

endmodule

[tb/tb_debug_link_packet_receiver.sv]
`timescale 1ns / 1ps
module tb_debug_link_packet_receiver;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [1:0] ACT_ERROR = 2'd1;
   localparam logic [1:0] ACT_ODD   = 2'd3;

   // Fixed expectations for the directed rows.
   localparam dlpr_pkg::result_type NO_RESULT  = '0;
   localparam dlpr_pkg::result_type FIN_TIMEO  = '{dlpr_pkg::KIND_FINISH, 8'd0, 16'd0, 32'd0,
                                                   dlpr_pkg::ST_TIMEOUT, 12'd0, 1'b1};
   localparam dlpr_pkg::result_type FIN_RESEND = '{dlpr_pkg::KIND_FINISH, 8'd0, 16'd0, 32'd0,
                                                   dlpr_pkg::ST_RESEND, 12'd0, 1'b1};
   localparam dlpr_pkg::result_type CTL_RESEND = '{dlpr_pkg::KIND_CTRL, 8'd0, dlpr_pkg::T_RESEND,
                                                   32'd0, dlpr_pkg::ST_RECEIVED, 12'd0, 1'b1};

   typedef struct {
      dlpr_pkg::item_type   ev;
      bit                   fixed;
      bit                   has_res;
      dlpr_pkg::result_type res;
   } row_type;

   logic clock;
   logic reset;

   dlpr_req_if req ();
   dlpr_rsp_if rsp ();
   dlpr_csr_if csr ();

   debug_link_packet_receiver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Shadow state of the receiver.
   dlpr_pkg::phase_type ph;
   logic [2:0]  lead_run;
   logic [7:0]  lead_byte;
   logic [1:0]  fidx;
   logic [15:0] pkt_type;
   logic [15:0] pkt_count;
   logic [31:0] pkt_id;
   logic [31:0] pkt_csum;
   logic [15:0] left;
   logic [31:0] sum;
   logic [31:0] id_exp;
   logic [31:0] id_send;
   logic [31:0] msg_len;
   logic [11:0] hdr_len;
   logic [15:0] max_cnt;

   dlpr_pkg::result_type step_res [2];
   int                   step_n;
   dlpr_pkg::result_type awaited_results [$];

   int  errors;
   int  cycles;
   int  items_sent;
   int  results_seen;
   int  kind_seen [4];
   bit  no_gaps;
   bit  hold_go;
   bit  hold_done;
   int  hold_left;

   // Clock.
   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   function automatic void emit(logic [1:0] k, logic [7:0] pb, logic [15:0] ct,
                                logic [31:0] cid, logic [1:0] st, logic [31:0] dl);
      dlpr_pkg::result_type r;
      if (step_n >= 2) return;
      r.kind = k;
      r.payload_byte = pb;
      r.control_type = ct;
      r.control_id = cid;
      r.status = st;
      r.data_length = (dl > 32'd4095) ? dlpr_pkg::DLEN_MAX : dl[11:0];
      r.last = 1'b0;
      step_res[step_n] = r;
      step_n++;
   endfunction

   function automatic void restart_search();
      ph = dlpr_pkg::PH_LEADER;
      lead_run = '0;
      lead_byte = '0;
   endfunction

   // Works out the results of one receive event and queues them.
   function automatic void decode_event(dlpr_pkg::item_type ev);
      logic [1:0]  act;
      logic [7:0]  b;
      logic [15:0] ex;
      logic [4:0]  sh;
      bit          done;
      act = ev.action;
      b = ev.rx_byte;
      ex = ev.expected_type;
      step_n = 0;
      case (ph)
         dlpr_pkg::PH_LEADER: begin
            if (act == dlpr_pkg::ACT_TIMEOUT) begin
               emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_TIMEOUT, '0);
               restart_search();
            end else if (act != dlpr_pkg::ACT_BYTE) begin
               lead_run = '0;
            end else if (b == dlpr_pkg::DATA_LEADER || b == dlpr_pkg::CTRL_LEADER) begin
               if (lead_run == 3'd0 || b != lead_byte) begin
                  lead_byte = b;
                  lead_run = 3'd1;
               end else begin
                  lead_run++;
               end
               if (lead_run >= 3'd4) begin
                  ph = dlpr_pkg::PH_TYPE;
                  fidx = '0;
                  pkt_type = '0;
                  pkt_count = '0;
                  pkt_id = '0;
                  pkt_csum = '0;
               end
            end else begin
               lead_run = '0;
            end
         end
         dlpr_pkg::PH_TYPE, dlpr_pkg::PH_COUNT, dlpr_pkg::PH_ID, dlpr_pkg::PH_CSUM: begin
            if (act == dlpr_pkg::ACT_TIMEOUT) begin
               emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_TIMEOUT, '0);
               restart_search();
            end else if (act != dlpr_pkg::ACT_BYTE) begin
               if (lead_byte != dlpr_pkg::CTRL_LEADER) begin
                  emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0, dlpr_pkg::ST_RECEIVED,
                       '0);
               end
               restart_search();
            end else begin
               sh = 5'(fidx) * 5'd8;
               case (ph)
                  dlpr_pkg::PH_TYPE:  pkt_type  = pkt_type | (16'(b) << sh);
                  dlpr_pkg::PH_COUNT: pkt_count = pkt_count | (16'(b) << sh);
                  dlpr_pkg::PH_ID:    pkt_id    = pkt_id | (32'(b) << sh);
                  default:            pkt_csum  = pkt_csum | (32'(b) << sh);
               endcase
               done = (ph == dlpr_pkg::PH_TYPE || ph == dlpr_pkg::PH_COUNT) ? (fidx >= 2'd1)
                                                                            : (fidx >= 2'd3);
               if (!done) begin
                  fidx++;
               end else begin
                  fidx = '0;
                  if (ph == dlpr_pkg::PH_TYPE) begin
                     if (lead_byte == dlpr_pkg::CTRL_LEADER && pkt_type == dlpr_pkg::T_RESEND) begin
                        emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RESEND, '0);
                        restart_search();
                     end else begin
                        ph = dlpr_pkg::PH_COUNT;
                     end
                  end else if (ph == dlpr_pkg::PH_COUNT) begin
                     ph = dlpr_pkg::PH_ID;
                  end else if (ph == dlpr_pkg::PH_ID) begin
                     ph = dlpr_pkg::PH_CSUM;
                  end else if (lead_byte == dlpr_pkg::CTRL_LEADER) begin
                     // Control packet: acknowledge, reset or resend.
                     if (pkt_type == dlpr_pkg::T_ACK) begin
                        if (pkt_id == (id_send & ~dlpr_pkg::SYNC_BIT) &&
                            ex == dlpr_pkg::T_ACK) begin
                           id_send ^= 32'd1;
                           emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RECEIVED, '0);
                        end
                     end else if (pkt_type == dlpr_pkg::T_RESET) begin
                        id_send = dlpr_pkg::INITIAL_ID;
                        id_exp = dlpr_pkg::INITIAL_ID;
                        emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESET, '0,
                             dlpr_pkg::ST_RECEIVED, '0);
                        emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RESEND, '0);
                     end else if (pkt_type == dlpr_pkg::T_RESEND) begin
                        emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RESEND, '0);
                     end
                     restart_search();
                  end else if (ex == dlpr_pkg::T_ACK) begin
                     // Data packet while only an acknowledge is awaited.
                     if (pkt_id == id_exp) begin
                        emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0,
                             dlpr_pkg::ST_RECEIVED, '0);
                        id_send ^= 32'd1;
                        emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RECEIVED, '0);
                     end else begin
                        emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_ACK, pkt_id,
                             dlpr_pkg::ST_RECEIVED, '0);
                     end
                     restart_search();
                  end else if (pkt_count > max_cnt || pkt_count < 16'(hdr_len)) begin
                     emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0,
                          dlpr_pkg::ST_RECEIVED, '0);
                     restart_search();
                  end else begin
                     msg_len = 32'(pkt_count) - 32'(hdr_len);
                     sum = '0;
                     if (hdr_len != 12'd0) begin
                        ph = dlpr_pkg::PH_HDR;
                        left = 16'(hdr_len);
                     end else if (msg_len != 32'd0) begin
                        ph = dlpr_pkg::PH_DATA;
                        left = msg_len[15:0];
                     end else begin
                        ph = dlpr_pkg::PH_TRAIL;
                     end
                  end
               end
            end
         end
         dlpr_pkg::PH_HDR, dlpr_pkg::PH_DATA: begin
            if (act != dlpr_pkg::ACT_BYTE) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0, dlpr_pkg::ST_RECEIVED, '0);
               restart_search();
            end else begin
               emit((ph == dlpr_pkg::PH_HDR) ? dlpr_pkg::KIND_HDR : dlpr_pkg::KIND_DATA, b,
                    '0, '0, dlpr_pkg::ST_RECEIVED, '0);
               sum += 32'(b);
               left--;
               if (left == 16'd0) begin
                  if (ph == dlpr_pkg::PH_HDR && msg_len != 32'd0) begin
                     ph = dlpr_pkg::PH_DATA;
                     left = msg_len[15:0];
                  end else begin
                     ph = dlpr_pkg::PH_TRAIL;
                  end
               end
            end
         end
         dlpr_pkg::PH_TRAIL: begin
            if (act != dlpr_pkg::ACT_BYTE || b != dlpr_pkg::TRAIL_BYTE) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0, dlpr_pkg::ST_RECEIVED, '0);
            end else if (ex != pkt_type) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_ACK, pkt_id, dlpr_pkg::ST_RECEIVED, '0);
            end else if (pkt_id != dlpr_pkg::INITIAL_ID &&
                         pkt_id != (dlpr_pkg::INITIAL_ID ^ 32'd1)) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0, dlpr_pkg::ST_RECEIVED, '0);
            end else if (pkt_id != id_exp) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_ACK, pkt_id, dlpr_pkg::ST_RECEIVED, '0);
            end else if (sum != pkt_csum) begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_RESEND, '0, dlpr_pkg::ST_RECEIVED, '0);
            end else begin
               emit(dlpr_pkg::KIND_CTRL, '0, dlpr_pkg::T_ACK, pkt_id, dlpr_pkg::ST_RECEIVED, '0);
               id_exp ^= 32'd1;
               emit(dlpr_pkg::KIND_FINISH, '0, '0, '0, dlpr_pkg::ST_RECEIVED, msg_len);
            end
            restart_search();
         end
         default: restart_search();
      endcase
      if (step_n > 0) step_res[step_n - 1].last = 1'b1;
      for (int i = 0; i < step_n; i++) awaited_results.push_back(step_res[i]);
   endfunction

   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(99) < 18);
   endfunction

   // Offers one item and waits until the block takes it.
   task automatic put_item(logic [1:0] a, logic [7:0] b, logic [15:0] e);
      dlpr_pkg::item_type ev;
      while (take_gap()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= a;
      req.rx_byte <= b;
      req.expected_type <= e;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      ev.action = a;
      ev.rx_byte = b;
      ev.expected_type = e;
      decode_event(ev);
      items_sent++;
   endtask

   // Sends a byte stream; at position cut a non-byte event replaces the rest.
   task automatic send_stream(logic [7:0] q [$], logic [15:0] e, int cut);
      for (int i = 0; i < q.size(); i++) begin
         if (i == cut) begin
            put_item(2'($urandom_range(3, 1)), 8'($urandom), e);
            return;
         end
         put_item(dlpr_pkg::ACT_BYTE, q[i], e);
      end
   endtask

   function automatic void push_le(ref logic [7:0] q [$], input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
   endfunction

   // Builds one packet with random content; most are well formed.
   task automatic send_packet(int max_dl);
      logic [7:0]  q [$];
      logic [7:0]  pay [$];
      logic [15:0] ty;
      logic [15:0] e;
      logic [31:0] cnt;
      logic [31:0] id;
      logic [31:0] cs;
      int          dl;
      int          pick;
      int          cut;
      pick = $urandom_range(99);
      cut = ($urandom_range(99) < 12) ? $urandom_range(30) : -1;
      // Stray leader-like bytes ahead of the packet.
      repeat ($urandom_range(2)) begin
         q.push_back($urandom_range(1) ? dlpr_pkg::DATA_LEADER : dlpr_pkg::CTRL_LEADER);
      end
      if (pick < 70) begin
         ty = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
         e = ($urandom_range(9) == 0) ? dlpr_pkg::T_ACK
             : (($urandom_range(9) == 0) ? 16'($urandom) : ty);
         dl = $urandom_range(max_dl);
         cnt = 32'(hdr_len) + 32'(dl);
         case ($urandom_range(9))
            0: cnt = 32'(max_cnt) + 32'd1;
            1: cnt = 32'($urandom_range(32'(hdr_len) + 32'(max_dl) + 32'd8));
            default: ;
         endcase
         cnt = cnt & 32'hFFFF;
         case ($urandom_range(9))
            0: id = 32'($urandom);
            1, 2: id = id_exp ^ 32'd1;
            default: id = id_exp;
         endcase
         cs = '0;
         if (e != dlpr_pkg::T_ACK && cnt <= 32'(max_cnt) && cnt >= 32'(hdr_len)) begin
            for (int i = 0; i < cnt; i++) begin
               pay.push_back(8'($urandom));
               cs += 32'(pay[i]);
            end
         end
         if ($urandom_range(9) == 0) cs = 32'($urandom);
         repeat (4) q.push_back(dlpr_pkg::DATA_LEADER);
         push_le(q, 32'(ty), 2);
         push_le(q, cnt, 2);
         push_le(q, id, 4);
         push_le(q, cs, 4);
         foreach (pay[i]) q.push_back(pay[i]);
         q.push_back(($urandom_range(19) == 0) ? 8'($urandom) : dlpr_pkg::TRAIL_BYTE);
      end else begin
         pick = $urandom_range(99);
         ty = (pick < 50) ? dlpr_pkg::T_ACK : (pick < 65) ? dlpr_pkg::T_RESET
              : (pick < 80) ? dlpr_pkg::T_RESEND : 16'($urandom);
         id = ($urandom_range(4) == 0) ? 32'($urandom) : (id_send & ~dlpr_pkg::SYNC_BIT);
         e = ($urandom_range(4) == 0) ? 16'($urandom) : dlpr_pkg::T_ACK;
         repeat (4) q.push_back(dlpr_pkg::CTRL_LEADER);
         push_le(q, 32'(ty), 2);
         push_le(q, 32'($urandom), 2);
         push_le(q, id, 4);
         push_le(q, 32'($urandom), 4);
      end
      send_stream(q, e, cut);
   endtask

   // Waits until the block has drained, then writes both registers.
   task automatic set_config(logic [11:0] h, logic [15:0] m);
      req.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= dlpr_pkg::REG_HDR_LEN;
      csr.data <= 16'(h);
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.index <= dlpr_pkg::REG_MAX_CNT;
      csr.data <= m;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      hdr_len = h;
      max_cnt = m;
   endtask

   // Receiver side: random stalls and one long hold-off.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= no_gaps || ($urandom_range(99) >= 18);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      dlpr_pkg::result_type got;
      dlpr_pkg::result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = rsp.kind;
         got.payload_byte = rsp.payload_byte;
         got.control_type = rsp.control_type;
         got.control_id = rsp.control_id;
         got.status = rsp.status;
         got.data_length = rsp.data_length;
         got.last = rsp.last;
         results_seen++;
         kind_seen[got.kind]++;
         if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result item: kind %0d", got.kind);
         end else begin
            want = awaited_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("Mismatch at result %0d:", results_seen);
                  $display("  expected kind %0d byte %h ctl %h id %h st %0d len %0d last %b",
                           want.kind, want.payload_byte, want.control_type, want.control_id,
                           want.status, want.data_length, want.last);
                  $display("  actual   kind %0d byte %h ctl %h id %h st %0d len %0d last %b",
                           got.kind, got.payload_byte, got.control_type, got.control_id,
                           got.status, got.data_length, got.last);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      row_type rows [25];
      int      budget;
      reset = 1'b1;
      req.valid <= 1'b0;
      req.action <= dlpr_pkg::ACT_BYTE;
      req.rx_byte <= '0;
      req.expected_type <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;
      errors = 0;
      cycles = 0;
      items_sent = 0;
      results_seen = 0;
      kind_seen = '{default: 0};
      no_gaps = 1'b0;
      hold_go = 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      hdr_len = dlpr_pkg::HDR_LEN_RESET;
      max_cnt = dlpr_pkg::MAX_CNT_RESET;
      id_exp = dlpr_pkg::INITIAL_ID;
      id_send = dlpr_pkg::INITIAL_ID | dlpr_pkg::SYNC_BIT;
      msg_len = '0;
      fidx = '0;
      pkt_type = '0;
      pkt_count = '0;
      pkt_id = '0;
      pkt_csum = '0;
      left = '0;
      sum = '0;
      restart_search();

      // Directed rows: timeouts, odd actions, control resend and header errors.
      rows[0]  = '{'{dlpr_pkg::ACT_TIMEOUT, 8'h00, 16'h0000}, 1, 1, FIN_TIMEO};
      rows[1]  = '{'{ACT_ODD, 8'hFF, 16'hFFFF}, 1, 0, NO_RESULT};
      rows[2]  = '{'{ACT_ERROR, 8'h00, 16'h0000}, 1, 0, NO_RESULT};
      rows[3]  = '{'{dlpr_pkg::ACT_BYTE, 8'hFF, 16'hFFFF}, 1, 0, NO_RESULT};
      for (int i = 4; i < 8; i++) begin
         rows[i] = '{'{dlpr_pkg::ACT_BYTE, dlpr_pkg::CTRL_LEADER, dlpr_pkg::T_ACK}, 0, 0,
                     NO_RESULT};
      end
      rows[8]  = '{'{dlpr_pkg::ACT_BYTE, 8'h05, dlpr_pkg::T_ACK}, 0, 0, NO_RESULT};
      rows[9]  = '{'{dlpr_pkg::ACT_BYTE, 8'h00, dlpr_pkg::T_ACK}, 1, 1, FIN_RESEND};
      for (int i = 10; i < 14; i++) begin
         rows[i] = '{'{dlpr_pkg::ACT_BYTE, dlpr_pkg::DATA_LEADER, 16'h0}, 0, 0, NO_RESULT};
      end
      rows[14] = '{'{dlpr_pkg::ACT_TIMEOUT, 8'h00, 16'h0000}, 1, 1, FIN_TIMEO};
      for (int i = 15; i < 19; i++) begin
         rows[i] = '{'{dlpr_pkg::ACT_BYTE, dlpr_pkg::CTRL_LEADER, 16'h0}, 0, 0, NO_RESULT};
      end
      rows[19] = '{'{ACT_ERROR, 8'h00, 16'h0000}, 1, 0, NO_RESULT};
      for (int i = 20; i < 24; i++) begin
         rows[i] = '{'{dlpr_pkg::ACT_BYTE, dlpr_pkg::DATA_LEADER, 16'hFFFF}, 0, 0, NO_RESULT};
      end
      rows[24] = '{'{ACT_ODD, 8'h00, 16'hFFFF}, 1, 1, CTL_RESEND};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         put_item(rows[i].ev.action, rows[i].ev.rx_byte, rows[i].ev.expected_type);
         if (rows[i].fixed) begin
            repeat (step_n) void'(awaited_results.pop_back());
            if (rows[i].has_res) awaited_results.push_back(rows[i].res);
         end
      end

      // Reset settings, with the long receiver hold-off at the start.
      hold_go = 1'b1;
      budget = items_sent + 250;
      while (items_sent < budget) send_packet(12);

      // No header, widest count, no idling on either side.
      set_config(12'd0, 16'hFFFF);
      no_gaps = 1'b1;
      budget = items_sent + 200;
      while (items_sent < budget) send_packet(10);
      no_gaps = 1'b0;

      // Short header, tight limit.
      set_config(12'd3, 16'd40);
      budget = items_sent + 250;
      while (items_sent < budget) send_packet(45);

      // Zero limit: only empty messages get through.
      set_config(12'd0, 16'd0);
      budget = items_sent + 120;
      while (items_sent < budget) send_packet(2);

      // Header of 4000 bytes with a limit below it: every data packet count is refused.
      set_config(12'd4000, 16'd3999);
      budget = items_sent + 80;
      while (items_sent < budget) send_packet(3);

      // Header longer than the limit allows.
      set_config(12'd1, 16'd0);
      budget = items_sent + 80;
      while (items_sent < budget) send_packet(4);

      set_config(12'd2, 16'd30);
      budget = items_sent + 150;
      while (items_sent < budget) begin
         if ($urandom_range(4) == 0) put_item(2'($urandom), 8'($urandom), 16'($urandom));
         else send_packet(8);
      end

      // Drain.
      req.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d receive events over seven register settings; checked %0d results.",
               items_sent, results_seen);
      $display("Header bytes %0d, data bytes %0d, control requests %0d, finishes %0d.",
               kind_seen[dlpr_pkg::KIND_HDR], kind_seen[dlpr_pkg::KIND_DATA],
               kind_seen[dlpr_pkg::KIND_CTRL], kind_seen[dlpr_pkg::KIND_FINISH]);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dlpr_pkg.sv
rtl/core/dlpr_if.sv
rtl/core/dlpr_deframer.sv
rtl/core/debug_link_packet_receiver.sv
tb/tb_debug_link_packet_receiver.sv
